@@ rtl/spd_pkg.sv @@
// Shared types, constants and word-layout functions for the sensor packet deframer.
// No dependencies; imported by spd_ctrl, spd_dp and the top level.
`timescale 1ns / 1ps
`default_nettype none

package spd_pkg;

  localparam logic [7:0] HDR_BYTE = 8'h55;
  localparam logic [7:0] TYPE_S   = 8'h53;
  localparam logic [7:0] TYPE_N   = 8'h4E;
  localparam logic [7:0] GPS_MARK = 8'h47;

  localparam int unsigned LEN_S       = 51;
  localparam int unsigned LEN_N       = 86;
  localparam int unsigned IDX_W       = 7;
  localparam int unsigned STORE_DEPTH = LEN_N;

  localparam logic [IDX_W-1:0] LEN_S_C   = IDX_W'(LEN_S);
  localparam logic [IDX_W-1:0] LEN_N_C   = IDX_W'(LEN_N);
  localparam logic [IDX_W-1:0] SBASE_S   = 7'd32;
  localparam logic [IDX_W-1:0] SBASE_N   = 7'd67;
  localparam logic [IDX_W-1:0] GPS_POS   = 7'd33;
  localparam logic [IDX_W-1:0] FIRST_BODY = 7'd3;

  localparam logic [4:0] WID_SENSOR_END = 5'd11;
  localparam logic [4:0] WID_SERVO      = 5'd11;
  localparam logic [4:0] WID_CH_LAST    = 5'd19;
  localparam logic [4:0] WID_GPS_FIRST  = 5'd20;
  localparam logic [4:0] WID_GPS_ALT    = 5'd26;
  localparam logic [4:0] WID_GPS_MARK   = 5'd27;

  localparam logic [1:0] CFG_AUTO_THR  = 2'd0;
  localparam logic [1:0] CFG_MAN_UPPER = 2'd1;
  localparam logic [1:0] CFG_HOLD      = 2'd2;

  localparam logic [15:0] AUTO_THR_RST  = 16'd12000;
  localparam logic [15:0] MAN_UPPER_RST = 16'd60000;
  localparam logic [3:0]  HOLD_RST      = 4'd15;

  typedef enum logic [1:0] {
    FS_OK       = 2'd0,
    FS_CKSUM    = 2'd1,
    FS_BAD_TYPE = 2'd2,
    FS_GPS_INV  = 2'd3
  } frame_status_t;

  typedef enum logic [6:0] {
    ST_HUNT = 7'b0000001,
    ST_TYPE = 7'b0000010,
    ST_BODY = 7'b0000100,
    ST_UPD  = 7'b0001000,
    ST_RD   = 7'b0010000,
    ST_ACC  = 7'b0100000,
    ST_LOAD = 7'b1000000
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic type_acc;
    logic body_acc;
    logic upd;
    logic rd;
    logic acc;
    logic load;
  } spd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic byte_is_hdr;
    logic type_ok;
    logic byte_last;
    logic no_read;
    logic byte_done;
    logic word_last;
    logic out_free;
  } spd_sts_t;

  // bytes read from the frame store for one word
  function automatic logic [2:0] word_nbytes(input logic [4:0] id);
    logic [2:0] n;
    if (id == WID_SERVO) n = 3'd1;
    else if (id >= WID_GPS_FIRST && id < WID_GPS_ALT) n = 3'd4;
    else if (id == WID_GPS_MARK) n = 3'd0;
    else n = 3'd2;
    return n;
  endfunction

  // store address of byte k of a word; little-endian words are walked downwards
  // so that every word assembles most significant byte first
  function automatic logic [IDX_W-1:0] word_addr(input logic [4:0] id, input logic is_n,
                                                 input logic [1:0] k);
    logic [IDX_W-1:0] sbase;
    logic [IDX_W-1:0] base;
    logic             down;
    sbase = is_n ? SBASE_N : SBASE_S;
    down  = 1'b0;
    if (id < 5'd9) begin
      base = 7'd3 + {1'b0, id, 1'b0};
    end else if (id < WID_SENSOR_END) begin
      base = 7'd9 + {1'b0, id, 1'b0};
    end else if (id == WID_SERVO) begin
      base = sbase;
    end else if (id <= WID_CH_LAST) begin
      base = sbase + {1'b0, id, 1'b0} - 7'd23;
    end else if (id < WID_GPS_ALT) begin
      base = {id, 2'b00} - 7'd43;
      down = 1'b1;
    end else begin
      base = 7'd59;
      down = 1'b1;
    end
    return down ? (base - {5'd0, k}) : (base + {5'd0, k});
  endfunction

endpackage

`default_nettype wire

@@ rtl/spd_ctrl.sv @@
// Controller state machine: header hunt, frame receive and word emission sequencing.
// Depends on spd_pkg; drives spd_dp through spd_cmd_t and reads spd_sts_t.
`timescale 1ns / 1ps
`default_nettype none

module spd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire spd_pkg::spd_sts_t sts,
  output spd_pkg::spd_cmd_t      cmd
);
  import spd_pkg::*;

  state_t state_r, state_nxt;
  logic   hdr_seen_r, hdr_seen_nxt;
  logic   in_acc;

  assign in_ready = (state_r == ST_HUNT) || (state_r == ST_TYPE) || (state_r == ST_BODY);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    state_nxt    = state_r;
    hdr_seen_nxt = hdr_seen_r;
    cmd          = '0;
    unique case (state_r)
      ST_HUNT: begin
        if (in_acc) begin
          if (sts.byte_is_hdr) begin
            hdr_seen_nxt = !hdr_seen_r;
            if (hdr_seen_r) state_nxt = ST_TYPE;
          end else begin
            hdr_seen_nxt = 1'b0;
          end
        end
      end
      ST_TYPE: begin
        if (in_acc) begin
          cmd.type_acc = 1'b1;
          state_nxt    = sts.type_ok ? ST_BODY : ST_UPD;
        end
      end
      ST_BODY: begin
        if (in_acc) begin
          cmd.body_acc = 1'b1;
          if (sts.byte_last) state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = ST_RD;
      end
      ST_RD: begin
        if (sts.no_read) begin
          state_nxt = ST_LOAD;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.byte_done ? ST_LOAD : ST_RD;
      end
      ST_LOAD: begin
        // hold until the output register can take the word
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = sts.word_last ? ST_HUNT : ST_RD;
        end
      end
      default: state_nxt = ST_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_HUNT;
      hdr_seen_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      hdr_seen_r <= hdr_seen_nxt;
    end
  end

  a_upd_to_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |=> (state_r == ST_RD))
    else $error("frame check not followed by emission");

  a_no_accept_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd || cmd.acc || cmd.load || cmd.upd) |-> !in_acc)
    else $error("request taken during emission");

  a_hdr_only_hunting: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_seen_r |-> (state_r == ST_HUNT))
    else $error("header count left set outside hunt");

endmodule

`default_nettype wire

@@ rtl/spd_dp.sv @@
// Datapath: frame store, checksum, field captures, mode override, word assembly, output register.
// Depends on spd_pkg; commanded by spd_ctrl through spd_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module spd_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [7:0]          in_rx_byte,
  input  wire logic                cfg_wr_en,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [15:0]         cfg_wr_data,
  input  wire spd_pkg::spd_cmd_t   cmd,
  output spd_pkg::spd_sts_t        sts,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [4:0]               out_word_id,
  output logic signed [31:0]       out_word_value,
  output logic [1:0]               out_frame_status,
  output logic                     out_autopilot_on,
  output logic                     out_last_of_frame
);
  import spd_pkg::*;

  // configuration
  logic [15:0] auto_thr_r, man_upper_r;
  logic [3:0]  hold_frames_r;

  // receive side
  logic [IDX_W-1:0] idx_r;
  logic             is_n_r, bad_type_r, ck_ok_r, gps_ok_r;
  logic [15:0]      sum_r;
  logic [7:0]       prev_r, ch5_hi_r, ch5_lo_r;
  logic [7:0]       store_mem [STORE_DEPTH];

  // mode override
  logic [15:0] ovr_ch_r;
  logic [4:0]  hold_cnt_r, hold_cnt_nxt;
  logic        ap_r, ap_nxt;
  logic [15:0] ch5_val;
  logic        frame_good;

  // emission
  frame_status_t    stat_r;
  logic [4:0]       wid_r;
  logic [1:0]       k_r;
  logic [31:0]      acc_r;
  logic [7:0]       rd_data_r;
  logic [2:0]       nbytes;
  logic [IDX_W-1:0] rd_addr, len, sbase;
  logic             out_free;
  logic [31:0]      word_val;

  logic             out_valid_r;
  logic [4:0]       out_id_r;
  logic [31:0]      out_val_r;
  frame_status_t    out_stat_r;
  logic             out_ap_r, out_last_r;

  assign len      = is_n_r ? LEN_N_C : LEN_S_C;
  assign sbase    = is_n_r ? SBASE_N : SBASE_S;
  assign nbytes   = word_nbytes(wid_r);
  assign rd_addr  = word_addr(wid_r, is_n_r, k_r);
  assign out_free = !out_valid_r || out_ready;

  assign sts.byte_is_hdr = (in_rx_byte == HDR_BYTE);
  assign sts.type_ok     = (in_rx_byte == TYPE_S) || (in_rx_byte == TYPE_N);
  assign sts.byte_last   = (idx_r == len - 7'd1);
  assign sts.no_read     = (stat_r != FS_OK) || (wid_r == WID_GPS_MARK);
  assign sts.byte_done   = ({1'b0, k_r} == nbytes - 3'd1);
  assign sts.word_last   = (stat_r != FS_OK) || (wid_r == WID_GPS_MARK) ||
                           (wid_r == WID_GPS_ALT) || ((wid_r == WID_CH_LAST) && !is_n_r);
  assign sts.out_free    = out_free;

  // channel five update: a bad frame keeps the previous value
  assign frame_good = !bad_type_r && ck_ok_r;
  assign ch5_val    = frame_good ? {ch5_hi_r, ch5_lo_r} : ovr_ch_r;

  always_comb begin
    hold_cnt_nxt = hold_cnt_r;
    ap_nxt       = ap_r;
    if (ch5_val <= auto_thr_r) begin
      ap_nxt       = 1'b1;
      hold_cnt_nxt = {1'b0, hold_frames_r};
    end else if (ch5_val < man_upper_r) begin
      if (hold_cnt_r[4]) ap_nxt = 1'b0;
      else hold_cnt_nxt = hold_cnt_r - 5'd1;
    end
  end

  always_comb begin
    unique case (nbytes)
      3'd1:    word_val = {24'd0, acc_r[7:0]};
      3'd2:    word_val = (wid_r < WID_SENSOR_END) ? {{16{acc_r[15]}}, acc_r[15:0]}
                                                   : {16'd0, acc_r[15:0]};
      default: word_val = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_thr_r    <= AUTO_THR_RST;
      man_upper_r   <= MAN_UPPER_RST;
      hold_frames_r <= HOLD_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_AUTO_THR:  auto_thr_r    <= cfg_wr_data;
        CFG_MAN_UPPER: man_upper_r   <= cfg_wr_data;
        CFG_HOLD:      hold_frames_r <= cfg_wr_data[3:0];
        default: ;
      endcase
    end
  end

  // frame store: written while receiving, read only while emitting
  always_ff @(posedge clk) begin
    if (cmd.body_acc) store_mem[idx_r] <= in_rx_byte;
    if (cmd.rd) rd_data_r <= store_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      is_n_r     <= 1'b0;
      bad_type_r <= 1'b0;
      ck_ok_r    <= 1'b0;
      sum_r      <= '0;
      ovr_ch_r   <= '0;
      hold_cnt_r <= '0;
      ap_r       <= 1'b0;
      stat_r     <= FS_OK;
      wid_r      <= '0;
      k_r        <= '0;
    end else begin
      if (cmd.type_acc) begin
        bad_type_r <= !sts.type_ok;
        is_n_r     <= (in_rx_byte == TYPE_N);
        sum_r      <= {8'd0, in_rx_byte};
        idx_r      <= FIRST_BODY;
      end
      if (cmd.body_acc) begin
        // trailer bytes stay out of the sum
        if (idx_r < len - 7'd2) sum_r <= sum_r + {8'd0, in_rx_byte};
        idx_r <= idx_r + 7'd1;
        if (sts.byte_last) ck_ok_r <= ({prev_r, in_rx_byte} == sum_r);
      end
      if (cmd.upd) begin
        if (frame_good) ovr_ch_r <= ch5_val;
        hold_cnt_r <= hold_cnt_nxt;
        ap_r       <= ap_nxt;
        stat_r     <= bad_type_r ? FS_BAD_TYPE : (ck_ok_r ? FS_OK : FS_CKSUM);
        wid_r      <= '0;
        k_r        <= '0;
      end
      if (cmd.acc) k_r <= sts.byte_done ? 2'd0 : k_r + 2'd1;
      if (cmd.load) begin
        // drop the GPS words when the marker byte is missing
        if (wid_r == WID_CH_LAST && is_n_r && !gps_ok_r) wid_r <= WID_GPS_MARK;
        else wid_r <= wid_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.body_acc) begin
      prev_r <= in_rx_byte;
      if (idx_r == sbase + 7'd9) ch5_hi_r <= in_rx_byte;
      if (idx_r == sbase + 7'd10) ch5_lo_r <= in_rx_byte;
      if (idx_r == GPS_POS) gps_ok_r <= (in_rx_byte == GPS_MARK);
    end
    if (cmd.acc) acc_r <= {acc_r[23:0], rd_data_r};
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_ap_r   <= ap_r;
      out_last_r <= sts.word_last;
      if (stat_r != FS_OK) begin
        out_id_r   <= '0;
        out_val_r  <= '0;
        out_stat_r <= stat_r;
      end else if (wid_r == WID_GPS_MARK) begin
        out_id_r   <= WID_GPS_MARK;
        out_val_r  <= '0;
        out_stat_r <= FS_GPS_INV;
      end else begin
        out_id_r   <= wid_r;
        out_val_r  <= word_val;
        out_stat_r <= FS_OK;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_word_id       = out_id_r;
  assign out_word_value    = $signed(out_val_r);
  assign out_frame_status  = out_stat_r;
  assign out_autopilot_on  = out_ap_r;
  assign out_last_of_frame = out_last_r;

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");

  a_hold_range: assert property (@(posedge clk) disable iff (!rst_n)
    hold_cnt_r[4] |-> (hold_cnt_r[3:0] == 4'hF))
    else $error("hold counter below minus one");

  a_write_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.body_acc |-> (idx_r < len))
    else $error("store write past frame end");

  a_read_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |-> ((rd_addr < len) && (rd_addr >= FIRST_BODY)))
    else $error("store read outside received bytes");

endmodule

`default_nettype wire

@@ rtl/sensor_packet_deframer_unit.sv @@
// Top level of the sensor packet deframer: joins controller and datapath.
// Depends on spd_pkg, spd_ctrl and spd_dp.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+---------------------------------------------
//  in_      | request   | in_valid / in_ready  | in_rx_byte
//  out_     | result    | out_valid/out_ready  | out_word_id, out_word_value, out_frame_status,
//           |           |                      | out_autopilot_on, out_last_of_frame
//  cfg_     | write     | cfg_wr_en            | cfg_index, cfg_wr_data
//
// A new byte is accepted every cycle while receiving.
// At frame end the checksum and mode update come first, then each word is read from the
// frame store a byte at a time through its single read port and assembled; the GPS marker
// needs no read, nor does an error status item. No request is taken while a frame drains.
// Reset (rst_n low, synchronous) restarts the header hunt and sets manual mode.
// A stalled result holds the drain; the last word may wait while new bytes arrive.
`timescale 1ns / 1ps
`default_nettype none

module sensor_packet_deframer_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_rx_byte,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [4:0]              out_word_id,
  output logic signed [31:0]      out_word_value,
  output logic [1:0]              out_frame_status,
  output logic                    out_autopilot_on,
  output logic                    out_last_of_frame,
  input  wire logic               cfg_wr_en,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_wr_data
);
  import spd_pkg::*;

  spd_cmd_t cmd;
  spd_sts_t sts;

  spd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  spd_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_rx_byte        (in_rx_byte),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wr_data       (cfg_wr_data),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_word_id       (out_word_id),
    .out_word_value    (out_word_value),
    .out_frame_status  (out_frame_status),
    .out_autopilot_on  (out_autopilot_on),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule

`default_nettype wire

@@ tb/spd_word_checker.sv @@
// Word checker for the sensor packet deframer: follows accepted bytes and register
// writes, predicts every decoded word and compares it with the result channel.
// Depends on spd_pkg for the header, type and status codes.
`timescale 1ns / 1ps

module spd_word_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [4:0]         out_word_id,
  input  logic signed [31:0] out_word_value,
  input  logic [1:0]         out_frame_status,
  input  logic               out_autopilot_on,
  input  logic               out_last_of_frame,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wr_data,
  output int                 mismatches,
  output int                 words_due,
  output int                 words_checked
);
  import spd_pkg::*;

  typedef enum logic [1:0] {
    HUNT_HDR,
    READ_TYPE,
    READ_BODY
  } rx_phase_t;

  typedef struct packed {
    logic [4:0]         id;
    logic signed [31:0] value;
    frame_status_t      status;
    logic               autopilot;
    logic               last;
  } frame_word_t;

  frame_word_t pending_words[$];

  logic [15:0] thr_auto;
  logic [15:0] thr_manual;
  logic [3:0]  hold_cfg;

  logic [1:0]  hdr_count;
  rx_phase_t   phase;
  logic [6:0]  idx;
  logic [7:0]  ftype;
  logic [7:0]  store [0:STORE_DEPTH-1];
  logic [15:0] csum;
  logic [15:0] ch5;
  int          hold_left;
  logic        autopilot;

  // mode flag follows channel five with a countdown before leaving autopilot
  function automatic void update_mode();
    if (ch5 <= thr_auto) begin
      autopilot = 1'b1;
      hold_left = int'(hold_cfg);
    end else if (ch5 < thr_manual) begin
      if (hold_left < 0) autopilot = 1'b0;
      else hold_left--;
    end
  endfunction

  function automatic void add_word(input int id, input logic [31:0] value,
                                   input frame_status_t status);
    frame_word_t w;
    w.id        = id[4:0];
    w.value     = value;
    w.status    = status;
    w.autopilot = autopilot;
    w.last      = 1'b0;
    pending_words.push_back(w);
  endfunction

  function automatic void decode_frame();
    int         flen;
    int         sb;
    int         p;
    int         i;
    logic [15:0] trailer;
    flen    = (ftype == TYPE_N) ? LEN_N : LEN_S;
    trailer = {store[flen-2], store[flen-1]};
    if (trailer != csum) begin
      // channel five keeps its old value on a bad checksum
      update_mode();
      add_word(0, 32'd0, FS_CKSUM);
    end else begin
      sb  = (ftype == TYPE_N) ? int'(SBASE_N) : int'(SBASE_S);
      ch5 = {store[sb+9], store[sb+10]};
      update_mode();
      for (i = 0; i < 11; i++) begin
        p = (i < 9) ? 3 + 2 * i : 9 + 2 * i;
        add_word(i, {{16{store[p][7]}}, store[p], store[p+1]}, FS_OK);
      end
      add_word(11, {24'd0, store[sb]}, FS_OK);
      for (i = 0; i < 8; i++)
        add_word(12 + i, {16'd0, store[sb+1+2*i], store[sb+2+2*i]}, FS_OK);
      if (ftype == TYPE_N) begin
        if (store[GPS_POS] == GPS_MARK) begin
          for (i = 0; i < 6; i++) begin
            p = 34 + 4 * i;
            add_word(20 + i, {store[p+3], store[p+2], store[p+1], store[p]}, FS_OK);
          end
          add_word(26, {16'd0, store[59], store[58]}, FS_OK);
        end else begin
          add_word(27, 32'd0, FS_GPS_INV);
        end
      end
    end
    pending_words[pending_words.size()-1].last = 1'b1;
  endfunction

  function automatic void absorb_rx_byte(input logic [7:0] b);
    logic [6:0] flen;
    case (phase)
      HUNT_HDR: begin
        if (b == HDR_BYTE) begin
          if (hdr_count == 2'd1) begin
            hdr_count = 2'd0;
            phase     = READ_TYPE;
          end else begin
            hdr_count = hdr_count + 2'd1;
          end
        end else begin
          hdr_count = 2'd0;
        end
      end
      READ_TYPE: begin
        hdr_count = 2'd0;
        if (b == TYPE_S || b == TYPE_N) begin
          ftype    = b;
          store[2] = b;
          csum     = {8'd0, b};
          idx      = FIRST_BODY;
          phase    = READ_BODY;
        end else begin
          phase = HUNT_HDR;
          update_mode();
          add_word(0, 32'd0, FS_BAD_TYPE);
          pending_words[pending_words.size()-1].last = 1'b1;
        end
      end
      default: begin
        flen       = (ftype == TYPE_N) ? LEN_N_C : LEN_S_C;
        store[idx] = b;
        if (idx < flen - 7'd2) csum = csum + {8'd0, b};
        idx = idx + 7'd1;
        if (idx >= flen) begin
          phase = HUNT_HDR;
          idx   = 7'd0;
          decode_frame();
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin
    frame_word_t exp_w;
    if (!rst_n) begin
      thr_auto   = AUTO_THR_RST;
      thr_manual = MAN_UPPER_RST;
      hold_cfg   = HOLD_RST;
      hdr_count  = 2'd0;
      phase      = HUNT_HDR;
      idx        = 7'd0;
      ftype      = 8'd0;
      csum       = 16'd0;
      ch5        = 16'd0;
      hold_left  = 0;
      autopilot  = 1'b0;
      pending_words.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_AUTO_THR:  thr_auto   = cfg_wr_data;
          CFG_MAN_UPPER: thr_manual = cfg_wr_data;
          CFG_HOLD:      hold_cfg   = cfg_wr_data[3:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pending_words.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word: id %0d value %0d status %0d", $time,
                   out_word_id, out_word_value, out_frame_status);
        end else begin
          exp_w = pending_words.pop_front();
          words_checked++;
          if (out_word_id !== exp_w.id || out_word_value !== exp_w.value ||
              out_frame_status !== exp_w.status || out_autopilot_on !== exp_w.autopilot ||
              out_last_of_frame !== exp_w.last) begin
            mismatches++;
            $display("%0t: word mismatch: expected id %0d value %0d status %0d ap %0b last %0b",
                     $time, exp_w.id, exp_w.value, exp_w.status, exp_w.autopilot, exp_w.last);
            $display("%0t:                  actual id %0d value %0d status %0d ap %0b last %0b",
                     $time, out_word_id, out_word_value, out_frame_status, out_autopilot_on,
                     out_last_of_frame);
          end
        end
      end
      if (in_valid && in_ready) absorb_rx_byte(in_rx_byte);
    end
    words_due <= pending_words.size();
  end

endmodule

@@ tb/tb.sv @@
// Testbench top for the sensor packet deframer: clock, reset, byte stimulus,
// register settings and the verdict. Depends on spd_pkg, the deframer and spd_word_checker.
`timescale 1ns / 1ps

module tb;
  import spd_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         in_rx_byte;
  logic               out_valid;
  logic               out_ready;
  logic [4:0]         out_word_id;
  logic signed [31:0] out_word_value;
  logic [1:0]         out_frame_status;
  logic               out_autopilot_on;
  logic               out_last_of_frame;
  logic               cfg_wr_en;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_wr_data;

  int          mismatches;
  int          words_due;
  int          words_checked;
  int          idle_pct;
  int          stall_pct;
  int          bytes_sent;
  int          frames_built;
  logic [15:0] auto_thr_now;
  logic [15:0] manual_up_now;
  logic [7:0]  byte_q[$];

  sensor_packet_deframer_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_word_id       (out_word_id),
    .out_word_value    (out_word_value),
    .out_frame_status  (out_frame_status),
    .out_autopilot_on  (out_autopilot_on),
    .out_last_of_frame (out_last_of_frame),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wr_data       (cfg_wr_data)
  );

  spd_word_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_word_id       (out_word_id),
    .out_word_value    (out_word_value),
    .out_frame_status  (out_frame_status),
    .out_autopilot_on  (out_autopilot_on),
    .out_last_of_frame (out_last_of_frame),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wr_data       (cfg_wr_data),
    .mismatches        (mismatches),
    .words_due         (words_due),
    .words_checked     (words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // hold valid and the byte until the request is taken
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_queued();
    while (byte_q.size() > 0) push_byte(byte_q.pop_front());
  endtask

  // drop valid and wait until every predicted word is out
  task automatic drain_words();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [7:0] noise_byte();
    return ($urandom_range(3) == 0) ? HDR_BYTE : 8'($urandom_range(255));
  endfunction

  function automatic void queue_header(input logic [7:0] type_byte);
    byte_q.push_back(HDR_BYTE);
    byte_q.push_back(HDR_BYTE);
    byte_q.push_back(type_byte);
  endfunction

  // fill < 0 gives random body bytes, otherwise every body byte is fill, bar channel five and the GPS marker
  function automatic void queue_frame(input logic [7:0] ftype, input bit good_sum,
                                      input bit has_gps, input logic [15:0] ch5,
                                      input int fill);
    logic [7:0]  fb [0:LEN_N-1];
    logic [15:0] sum;
    int          flen;
    int          sb;
    int          i;
    flen = (ftype == TYPE_N) ? LEN_N : LEN_S;
    sb   = (ftype == TYPE_N) ? int'(SBASE_N) : int'(SBASE_S);
    for (i = 3; i < flen - 2; i++)
      fb[i] = (fill < 0) ? 8'($urandom_range(255)) : fill[7:0];
    fb[0]    = HDR_BYTE;
    fb[1]    = HDR_BYTE;
    fb[2]    = ftype;
    fb[sb+9]  = ch5[15:8];
    fb[sb+10] = ch5[7:0];
    if (ftype == TYPE_N) begin
      if (has_gps) fb[GPS_POS] = GPS_MARK;
      else if (fb[GPS_POS] == GPS_MARK) fb[GPS_POS] = GPS_MARK ^ 8'h01;
    end
    sum = 16'd0;
    for (i = 2; i < flen - 2; i++) sum = sum + {8'd0, fb[i]};
    if (!good_sum) sum = sum ^ 16'($urandom_range(65535, 1));
    fb[flen-2] = sum[15:8];
    fb[flen-1] = sum[7:0];
    for (i = 0; i < flen; i++) byte_q.push_back(fb[i]);
    frames_built++;
  endfunction

  // channel five around the current thresholds, weighted to the countdown band
  function automatic logic [15:0] pick_ch5();
    int a;
    int m;
    a = int'(auto_thr_now);
    m = int'(manual_up_now);
    case ($urandom_range(9))
      0:       return 16'($urandom_range(a));
      1:       return 16'(a);
      2:       return 16'(a + 1);
      3:       return 16'(m - 1);
      4:       return 16'(m);
      5, 6, 7: return (m > a + 1) ? 16'($urandom_range(m - 1, a + 1))
                                  : 16'($urandom_range(65535));
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
  endtask

  task automatic set_mode_regs(input logic [15:0] a, input logic [15:0] m,
                               input logic [3:0] h);
    drain_words();
    write_reg(CFG_AUTO_THR, a);
    write_reg(CFG_MAN_UPPER, m);
    write_reg(CFG_HOLD, {12'd0, h});
    cfg_wr_en     <= 1'b0;
    auto_thr_now  = a;
    manual_up_now = m;
  endtask

  task automatic random_sequence();
    logic [7:0] b;
    int         r;
    int         n;
    r = $urandom_range(99);
    if (r < 72) begin
      if ($urandom_range(3) == 0) begin
        n = $urandom_range(3, 1);
        repeat (n) byte_q.push_back(noise_byte());
      end
      queue_frame($urandom_range(1) ? TYPE_N : TYPE_S, $urandom_range(99) < 85,
                  $urandom_range(99) < 60, pick_ch5(), -1);
    end else if (r < 84) begin
      b = 8'($urandom_range(255));
      if (b == TYPE_S || b == TYPE_N) b = HDR_BYTE;
      queue_header(b);
    end else if (r < 94) begin
      n = $urandom_range(8, 1);
      repeat (n) byte_q.push_back(noise_byte());
    end else begin
      // cut a frame short; the following bytes complete it
      queue_header($urandom_range(1) ? TYPE_N : TYPE_S);
      n = $urandom_range(40, 1);
      repeat (n) byte_q.push_back(8'($urandom_range(255)));
    end
    send_queued();
    if ($urandom_range(99) < 4) drain_words();
  endtask

  initial begin
    int ph;
    int s;
    in_valid    <= 1'b0;
    in_rx_byte  <= 8'd0;
    cfg_wr_en   <= 1'b0;
    cfg_index   <= CFG_AUTO_THR;
    cfg_wr_data <= 16'd0;
    rst_n       <= 1'b0;
    idle_pct      = 0;
    stall_pct     = 0;
    bytes_sent    = 0;
    frames_built  = 0;
    auto_thr_now  = AUTO_THR_RST;
    manual_up_now = MAN_UPPER_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed frames under the reset thresholds
    byte_q.push_back(8'h00);
    byte_q.push_back(8'hFF);
    byte_q.push_back(HDR_BYTE);
    byte_q.push_back(8'h12);
    queue_header(8'h00);
    queue_header(HDR_BYTE);
    queue_header(8'hFF);
    queue_frame(TYPE_S, 1'b1, 1'b0, 16'd0, 'hFF);
    queue_frame(TYPE_N, 1'b1, 1'b1, 16'hFFFF, 'hFF);
    queue_frame(TYPE_N, 1'b1, 1'b0, 16'd30000, 'h00);
    queue_frame(TYPE_N, 1'b1, 1'b1, 16'd12000, 'h80);
    queue_frame(TYPE_S, 1'b0, 1'b0, 16'd12001, -1);
    queue_frame(TYPE_N, 1'b0, 1'b1, 16'd59999, -1);
    queue_frame(TYPE_S, 1'b1, 1'b0, 16'd12001, 'h7F);
    queue_frame(TYPE_S, 1'b1, 1'b0, 16'd60000, -1);
    queue_frame(TYPE_N, 1'b1, 1'b1, 16'd59999, -1);
    send_queued();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          set_mode_regs(16'd0, 16'hFFFF, 4'd0);
          idle_pct = 0;  stall_pct = 0;
        end
        1: begin
          set_mode_regs(16'hFFFF, 16'd0, 4'd15);
          idle_pct = 66; stall_pct = 0;
        end
        2: begin
          s = $urandom_range(30000, 1000);
          set_mode_regs(16'(s), 16'(s + $urandom_range(30000, 2)), 4'($urandom_range(15)));
          idle_pct = 0;  stall_pct = 66;
        end
        default: begin
          set_mode_regs(16'd40000, 16'd40001, 4'($urandom_range(15)));
          idle_pct = 8;  stall_pct = 8;
        end
      endcase
      for (s = 0; s < 14; s++) random_sequence();
    end

    drain_words();
    repeat (200) @(posedge clk);
    $display("summary: %0d bytes sent, %0d frames built, %0d words checked",
             bytes_sent, frames_built, words_checked);
    $display("summary: four handshake phases, threshold extremes and an empty countdown band");
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule
